FILE: hdl/vlfs_pkg.sv
// Package for the varint length frame splitter.
// Holds field widths, the length-field byte limit default, register reset value and status codes; no dependencies.
`default_nettype none

package vlfs_pkg;

  // Width of the length accumulator, payload counter and frame total.
  localparam int LenBits = 21;

  // Default for the most varint bytes that one length field may use.
  localparam int MaxLenBytesDefault = 10;

  // Reset value of the maximum frame length register.
  localparam logic [LenBits-1:0] MaxFrameReset = LenBits'(16384);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_OVERLONG = 2'd2,
    ST_CLOSED   = 2'd3
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/varint_length_frame_splitter.sv
// Varint length-prefixed frame splitter: top level.
// Depends on vlfs_pkg for widths, reset value and status codes.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one received byte per
//   transfer, or a link-closed indication. Every transfer while the stream is
//   open yields exactly one result on the output channel (out_valid /
//   out_stall): the byte with frame start, header and frame end flags, the
//   total frame length on the frame's last byte, and a status code.
//   A frame is a type byte, a little-endian base-128 length of 1 to
//   MAX_LENGTH_BYTES bytes, then the payload.
//   Throughput is one byte per cycle while out_stall is low; the parser state
//   is updated in the cycle of the input transfer and the result sits in the
//   output register from the next cycle.
//   A frame longer than the configured maximum, an unterminated length field
//   or a link close ends the stream: that item's result carries the status,
//   and later items are taken and dropped until reset.
//   When the receiver stalls, the output register holds its result and
//   in_stall rises, so nothing is lost.
//   Reset (rst_n low, synchronous) returns to expecting a type byte and sets
//   the maximum frame length to 16384. The user writes cfg_max_frame_bytes
//   while idle (unenforced) through cfg_valid; cfg_ready is always high.
`default_nettype none

module varint_length_frame_splitter
  import vlfs_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MaxLenBytesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LenBits-1:0] cfg_max_frame_bytes,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_link_closed,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_frame_start,
  output logic                    out_in_header,
  output logic                    out_frame_end,
  output logic [LenBits-1:0]      out_frame_total,
  output logic [1:0]              out_status
);

  localparam int CntW = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int ShW  = CntW + 3;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_DEAD = 2'd3
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [LenBits-1:0] acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [LenBits-1:0] rem_r, rem_nxt;
  logic [LenBits-1:0] tot_r, tot_nxt;
  status_t            sticky_r, sticky_nxt;
  logic [LenBits-1:0] max_r;

  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_start_r;
  logic               out_hdr_r;
  logic               out_end_r;
  logic [LenBits-1:0] out_total_r;
  status_t            out_status_r;

  logic               res_valid;
  logic [7:0]         res_byte;
  logic               res_start;
  logic               res_hdr;
  logic               res_end;
  logic [LenBits-1:0] res_total;
  status_t            res_status;

  logic               in_xfer;
  logic               out_load;

  // length-field decode
  logic [6:0]         data7;
  logic [ShW-1:0]     sh;
  logic [LenBits+6:0] shifted;
  logic [CntW:0]      k_new;
  logic [LenBits-1:0] acc_upd;
  logic               ovf_upd;
  logic [LenBits:0]   total;
  logic [LenBits-1:0] rem_dec;

  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign data7   = in_byte[6:0];
  assign sh      = ShW'(cnt_r) * ShW'(7);
  assign shifted = {{LenBits{1'b0}}, data7} << sh;
  assign k_new   = {1'b0, cnt_r} + (CntW + 1)'(1);
  assign rem_dec = rem_r - LenBits'(1);

  always_comb begin
    acc_upd = acc_r;
    ovf_upd = ovf_r;
    if (data7 != 7'd0) begin
      // data bits landing at or above the accumulator width set the overflow flag
      if (32'(sh) >= 32'(LenBits)) begin
        ovf_upd = 1'b1;
      end else begin
        if (shifted[LenBits+6:LenBits] != 7'd0) begin
          ovf_upd = 1'b1;
        end
        acc_upd = acc_r | shifted[LenBits-1:0];
      end
    end
  end

  assign total = {1'b0, acc_upd} + (LenBits + 1)'(k_new) + (LenBits + 1)'(1);

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    tot_nxt    = tot_r;
    sticky_nxt = sticky_r;
    res_valid  = 1'b0;
    res_byte   = in_byte;
    res_start  = 1'b0;
    res_hdr    = 1'b0;
    res_end    = 1'b0;
    res_total  = '0;
    res_status = ST_OK;
    if (in_xfer && phase_r != PH_DEAD && sticky_r == ST_OK) begin
      res_valid = 1'b1;
      if (in_link_closed) begin
        phase_nxt  = PH_DEAD;
        sticky_nxt = ST_CLOSED;
        res_byte   = 8'd0;
        res_status = ST_CLOSED;
      end else begin
        unique case (phase_r)
          PH_TYPE: begin
            acc_nxt   = '0;
            ovf_nxt   = 1'b0;
            cnt_nxt   = '0;
            rem_nxt   = '0;
            tot_nxt   = '0;
            phase_nxt = PH_LEN;
            res_start = 1'b1;
            res_hdr   = 1'b1;
          end
          PH_LEN: begin
            res_hdr = 1'b1;
            acc_nxt = acc_upd;
            ovf_nxt = ovf_upd;
            cnt_nxt = k_new[CntW-1:0];
            if (in_byte[7]) begin
              if (32'(k_new) >= 32'(MAX_LENGTH_BYTES)) begin
                phase_nxt  = PH_DEAD;
                sticky_nxt = ST_OVERLONG;
                res_status = ST_OVERLONG;
              end
            end else if (ovf_upd || total > {1'b0, max_r}) begin
              phase_nxt  = PH_DEAD;
              sticky_nxt = ST_TOO_LONG;
              res_status = ST_TOO_LONG;
            end else begin
              tot_nxt = total[LenBits-1:0];
              rem_nxt = acc_upd;
              if (acc_upd == '0) begin
                // empty payload: the last length byte closes the frame
                phase_nxt = PH_TYPE;
                res_end   = 1'b1;
                res_total = total[LenBits-1:0];
              end else begin
                phase_nxt = PH_PAY;
              end
            end
          end
          PH_PAY: begin
            rem_nxt = rem_dec;
            if (rem_r == LenBits'(1)) begin
              phase_nxt = PH_TYPE;
              res_end   = 1'b1;
              res_total = tot_r;
            end
          end
          default: begin
            phase_nxt = PH_DEAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      rem_r       <= '0;
      tot_r       <= '0;
      sticky_r    <= ST_OK;
      max_r       <= MaxFrameReset;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      cnt_r    <= cnt_nxt;
      rem_r    <= rem_nxt;
      tot_r    <= tot_nxt;
      sticky_r <= sticky_nxt;
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_max_frame_bytes;
      end
      if (out_load) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r   <= res_byte;
      out_start_r  <= res_start;
      out_hdr_r    <= res_hdr;
      out_end_r    <= res_end;
      out_total_r  <= res_total;
      out_status_r <= res_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_frame_start = out_start_r;
  assign out_in_header   = out_hdr_r;
  assign out_frame_end   = out_end_r;
  assign out_frame_total = out_total_r;
  assign out_status      = out_status_r;

  // an error or close result leaves the parser closed for good
  a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> phase_r == PH_DEAD)
    else $error("error result without closed stream");

  // a frame is at least a type byte and one length byte
  a_end_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_total_r >= LenBits'(2) && !out_start_r)
    else $error("frame end with bad total");

  a_err_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> !out_end_r && out_total_r == '0)
    else $error("error result marked as frame end");

  a_start_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_start_r |-> out_hdr_r && out_total_r == '0)
    else $error("type byte without header flag");

  a_dead_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DEAD && out_load |=> !out_valid_r)
    else $error("result produced after stream closed");

  a_pay_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> rem_r != '0)
    else $error("payload phase with nothing left");

endmodule

`default_nettype wire
